// ===== sv/ldq_pkg.sv =====
// Package for the launch detect qualifier: word types, status codes and
// register indexes. No dependencies.
package ldq_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_ACCEL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHAKE_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TENTHS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ATT_CHECK    = 3'd4;

	localparam logic [3:0] ST_DISARMED = 4'd0;
	localparam logic [3:0] ST_GAP      = 4'd1;
	localparam logic [3:0] ST_RUDDER   = 4'd2;
	localparam logic [3:0] ST_NO_FIX   = 4'd3;
	localparam logic [3:0] ST_NO_ACCEL = 4'd4;
	localparam logic [3:0] ST_TIMING   = 4'd5;
	localparam logic [3:0] ST_TIMEOUT  = 4'd6;
	localparam logic [3:0] ST_BAD_ATT  = 4'd7;
	localparam logic [3:0] ST_LAUNCHED = 4'd8;

	localparam logic [31:0] GAP_MS      = 32'd200;
	localparam logic [31:0] SHAKE_WIN_MS = 32'd500;
	localparam logic [31:0] WAIT_SLACK_MS = 32'd100;
	localparam logic signed [15:0] PITCH_LO = -16'sd3000;
	localparam logic signed [15:0] PITCH_HI = 16'sd4500;
	localparam logic signed [15:0] ROLL_LIM = 16'sd3000;
	localparam logic [7:0]  DELAY_CLAMP = 8'd127;
	localparam logic [13:0] WAIT_MAX_MS = 14'd12700;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic               armed;
		logic               rudder_armed;
		logic               rudder_neutral_seen;
		logic               gps_3d_fix;
		logic signed [15:0] fwd_accel;
		logic signed [15:0] pitch_cdeg;
		logic signed [15:0] roll_cdeg;
		logic [15:0]        gnd_speed;
		logic               inverted_flight;
	} chk_t;

	typedef struct packed {
		logic       launch;
		logic       rudder_wait;
		logic [3:0] status;
	} res_t;

endpackage

// ===== sv/ldq_chk_if.sv =====
// Check channel of the launch detect qualifier: valid/ready plus a check word.
// Depends on ldq_pkg.
interface ldq_chk_if;
	logic          valid;
	logic          ready;
	ldq_pkg::chk_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/ldq_res_if.sv =====
// Result channel of the launch detect qualifier: valid/ready plus a result word.
// Depends on ldq_pkg.
interface ldq_res_if;
	logic          valid;
	logic          ready;
	ldq_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/launch_detect_qualifier.sv =====
// Launch detect qualifier top level.
// Depends on ldq_pkg, ldq_chk_if and ldq_res_if.
//
// Usage:
//   chk carries one check word per tick (time, arm/rudder/fix flags, forward
//   accel, attitude, ground speed). res returns exactly one word per check:
//   launch flag, rudder wait flag and a status code.
//   Settings are written through wr_en/wr_idx/wr_data while no check is in
//   flight; unknown indexes are dropped.
//   Flow: an accepted check is registered in the input register, evaluated
//   against the qualifier state and loaded into the result register for res.
//   Throughput: one check per cycle while res is taken. The qualifier state is updated at the
//   same edge that loads the result register, so the following check already
//   sees it; the evaluation is comparisons and 32-bit wrapping subtracts.
//   Stall: when res is not taken, the result register holds; the input
//   register still takes one more check if it is empty, then chk.ready drops
//   until the result drains.
//   Reset (arst_n low): all qualifier state clears, settings return to their
//   defaults (attitude check on, others zero), both channels empty.
module launch_detect_qualifier (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [ldq_pkg::CFG_IDX_W-1:0]          wr_idx,
	input  logic [ldq_pkg::CFG_DATA_W-1:0]         wr_data,
	ldq_chk_if.sink                                chk,
	ldq_res_if.source                              res
);

	// settings
	logic [14:0] min_accel_q;
	logic [6:0]  shake_count_q;
	logic [13:0] wait_ms_q;
	logic [15:0] min_speed_q;
	logic        att_check_q;

	// qualifier state
	logic [31:0] last_check_q;
	logic        timer_run_q;
	logic [31:0] timer_start_q;
	logic [7:0]  shake_q;
	logic [31:0] last_shake_q;
	logic        wait_rudder_q;

	// pipeline
	logic          vld_s1;
	ldq_pkg::chk_t chk_s1;
	logic          res_vld_q;
	ldq_pkg::res_t res_q;
	logic          adv_s1;

	// next values
	logic [31:0] nx_last_check;
	logic        nx_timer_run;
	logic [31:0] nx_timer_start;
	logic [7:0]  nx_shake;
	logic [31:0] nx_last_shake;
	logic        nx_wait_rudder;
	logic [3:0]  nx_status;

	logic [13:0] delay_ms;

	assign adv_s1    = vld_s1 && (!res_vld_q || res.ready);
	assign chk.ready = !vld_s1 || adv_s1;
	assign res.valid = res_vld_q;
	assign res.data  = res_q;

	// wait = min(tenths * 100, 12700), worked out once at write time
	assign delay_ms = (wr_data[7:0] >= ldq_pkg::DELAY_CLAMP) ? ldq_pkg::WAIT_MAX_MS :
		14'(wr_data[7:0] * 14'd100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_accel_q   <= '0;
			shake_count_q <= '0;
			wait_ms_q     <= '0;
			min_speed_q   <= '0;
			att_check_q   <= 1'b1;
		end else if (wr_en) begin
			case (wr_idx)
				ldq_pkg::REG_MIN_ACCEL:    min_accel_q   <= wr_data[14:0];
				ldq_pkg::REG_SHAKE_COUNT:  shake_count_q <= wr_data[6:0];
				ldq_pkg::REG_DELAY_TENTHS: wait_ms_q     <= delay_ms;
				ldq_pkg::REG_MIN_SPEED:    min_speed_q   <= wr_data[15:0];
				ldq_pkg::REG_ATT_CHECK:    att_check_q   <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic signed [16:0] accel;
		logic signed [16:0] thr;
		logic [31:0]        start;
		logic [31:0]        elapsed;
		logic               got;
		logic               fail;
		logic               bad_att;

		accel   = {chk_s1.fwd_accel[15], chk_s1.fwd_accel};
		thr     = $signed({2'b00, min_accel_q});
		start   = timer_run_q ? timer_start_q : chk_s1.now_ms;
		elapsed = chk_s1.now_ms - start;
		got     = 1'b0;
		fail    = 1'b0;
		bad_att = 1'b0;

		nx_last_check  = last_check_q;
		nx_timer_run   = timer_run_q;
		nx_timer_start = timer_start_q;
		nx_shake       = shake_q;
		nx_last_shake  = last_shake_q;
		nx_wait_rudder = wait_rudder_q;
		nx_status      = ldq_pkg::ST_TIMING;

		if (!chk_s1.armed || (last_check_q != 32'd0 &&
				(chk_s1.now_ms - last_check_q) > ldq_pkg::GAP_MS)) begin
			nx_last_check  = '0;
			nx_timer_run   = 1'b0;
			nx_timer_start = '0;
			nx_shake       = '0;
			nx_last_shake  = '0;
			nx_wait_rudder = 1'b0;
			nx_status      = chk_s1.armed ? ldq_pkg::ST_GAP : ldq_pkg::ST_DISARMED;
		end else begin
			nx_last_check = chk_s1.now_ms;
			if (chk_s1.rudder_armed && !chk_s1.rudder_neutral_seen) begin
				nx_wait_rudder = 1'b1;
				nx_status      = ldq_pkg::ST_RUDDER;
			end else begin
				nx_wait_rudder = 1'b0;
				if (!chk_s1.gps_3d_fix) begin
					nx_status = ldq_pkg::ST_NO_FIX;
				end else begin
					if (!timer_run_q && min_accel_q != 15'd0) begin
						if (shake_count_q <= 7'd1) begin
							fail = accel < thr;
						end else begin
							if ((chk_s1.now_ms - last_shake_q) > ldq_pkg::SHAKE_WIN_MS)
								nx_shake = '0;
							// odd count wants a negative swing, even a positive one
							got = nx_shake[0] ? (accel < -thr) : (accel > thr);
							if (got) begin
								if (nx_shake != 8'hFF)
									nx_shake = nx_shake + 8'd1;
								nx_last_shake = chk_s1.now_ms;
							end
							fail = nx_shake < {1'b0, shake_count_q};
						end
					end
					bad_att = att_check_q && (chk_s1.pitch_cdeg <= ldq_pkg::PITCH_LO ||
						chk_s1.pitch_cdeg >= ldq_pkg::PITCH_HI ||
						(!chk_s1.inverted_flight && (chk_s1.roll_cdeg > ldq_pkg::ROLL_LIM ||
						chk_s1.roll_cdeg < -ldq_pkg::ROLL_LIM)));
					nx_timer_run   = 1'b0;
					nx_timer_start = '0;
					if (fail) begin
						nx_status = ldq_pkg::ST_NO_ACCEL;
					end else if (elapsed > {18'd0, wait_ms_q} + ldq_pkg::WAIT_SLACK_MS) begin
						nx_status = ldq_pkg::ST_TIMEOUT;
					end else if (bad_att) begin
						nx_shake  = '0;
						nx_status = ldq_pkg::ST_BAD_ATT;
					end else if ((chk_s1.gnd_speed > min_speed_q || min_speed_q == 16'd0) &&
							elapsed >= {18'd0, wait_ms_q}) begin
						nx_status = ldq_pkg::ST_LAUNCHED;
					end else begin
						nx_timer_run   = 1'b1;
						nx_timer_start = start;
						nx_status      = ldq_pkg::ST_TIMING;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			res_vld_q     <= 1'b0;
			last_check_q  <= '0;
			timer_run_q   <= 1'b0;
			timer_start_q <= '0;
			shake_q       <= '0;
			last_shake_q  <= '0;
			wait_rudder_q <= 1'b0;
		end else begin
			if (chk.ready)
				vld_s1 <= chk.valid;
			if (adv_s1)
				res_vld_q <= 1'b1;
			else if (res.ready)
				res_vld_q <= 1'b0;
			if (adv_s1) begin
				last_check_q  <= nx_last_check;
				timer_run_q   <= nx_timer_run;
				timer_start_q <= nx_timer_start;
				shake_q       <= nx_shake;
				last_shake_q  <= nx_last_shake;
				wait_rudder_q <= nx_wait_rudder;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chk.valid && chk.ready)
			chk_s1 <= chk.data;
		if (adv_s1) begin
			res_q.launch      <= (nx_status == ldq_pkg::ST_LAUNCHED);
			res_q.rudder_wait <= nx_wait_rudder;
			res_q.status      <= nx_status;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		chk.valid && chk.ready |-> !vld_s1 || adv_s1)
		else $error("input register overwritten before it advanced");

	a_launch_stops_timer: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && nx_status == ldq_pkg::ST_LAUNCHED |=> !timer_run_q && timer_start_q == 32'd0)
		else $error("timer still running after launch");

	a_disarm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !chk_s1.armed |=> last_check_q == 32'd0 && shake_q == 8'd0 && !wait_rudder_q)
		else $error("state not cleared on disarm");

	a_timing_runs: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && nx_status == ldq_pkg::ST_TIMING |=> timer_run_q)
		else $error("timing status without running timer");

endmodule

// ===== bench/tb_launch_detect_qualifier.sv =====
`timescale 1ns / 100ps
// Self-checking bench for launch_detect_qualifier: a scoreboard class predicts
// the result word of every accepted check. Depends on ldq_pkg and the channel interfaces.
module tb_launch_detect_qualifier;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES = 8;
	localparam int CHECKS_PER_PHASE = 190;

	class launch_scoreboard;
		logic [14:0] min_accel;
		logic [6:0]  shake_count;
		logic [7:0]  delay_tenths;
		logic [15:0] min_speed;
		logic        att_on;

		logic [31:0] prev_check_ms;
		logic        timer_on;
		logic [31:0] timer_start_ms;
		logic [7:0]  shake_events;
		logic [31:0] last_shake_ms;
		logic        rudder_hold;

		ldq_pkg::res_t expected_q[$];
		int            errors;

		function new();
			min_accel = '0;
			shake_count = '0;
			delay_tenths = '0;
			min_speed = '0;
			att_on = 1'b1;
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			prev_check_ms = '0;
			timer_on = 1'b0;
			timer_start_ms = '0;
			shake_events = '0;
			last_shake_ms = '0;
			rudder_hold = 1'b0;
		endfunction

		function void write_reg(logic [ldq_pkg::CFG_IDX_W-1:0] idx,
				logic [ldq_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ldq_pkg::REG_MIN_ACCEL:    min_accel = data[14:0];
				ldq_pkg::REG_SHAKE_COUNT:  shake_count = data[6:0];
				ldq_pkg::REG_DELAY_TENTHS: delay_tenths = data[7:0];
				ldq_pkg::REG_MIN_SPEED:    min_speed = data[15:0];
				ldq_pkg::REG_ATT_CHECK:    att_on = data[0];
				default: ;
			endcase
		endfunction

		function void post(logic [3:0] st);
			ldq_pkg::res_t r;
			r.launch = (st == ldq_pkg::ST_LAUNCHED);
			r.rudder_wait = rudder_hold;
			r.status = st;
			expected_q.push_back(r);
		endfunction

		function void halt_timer(logic [3:0] st);
			timer_on = 1'b0;
			timer_start_ms = '0;
			post(st);
		endfunction

		function void note_check(ldq_pkg::chk_t c);
			logic [31:0] wait_ms;
			logic [31:0] elapsed;
			int thr, accel, pitch, roll_abs;
			bit got;
			wait_ms = delay_tenths * 100;
			if (wait_ms > ldq_pkg::WAIT_MAX_MS)
				wait_ms = 32'(ldq_pkg::WAIT_MAX_MS);
			thr = int'(min_accel);
			accel = int'(c.fwd_accel);
			pitch = int'(c.pitch_cdeg);
			roll_abs = int'(c.roll_cdeg);
			if (roll_abs < 0)
				roll_abs = -roll_abs;

			if (!c.armed) begin
				clear_state();
				post(ldq_pkg::ST_DISARMED);
				return;
			end
			elapsed = c.now_ms - prev_check_ms;
			// zero stored time means never checked
			if (prev_check_ms != 0 && elapsed > ldq_pkg::GAP_MS) begin
				clear_state();
				post(ldq_pkg::ST_GAP);
				return;
			end
			prev_check_ms = c.now_ms;

			if (c.rudder_armed && !c.rudder_neutral_seen) begin
				rudder_hold = 1'b1;
				post(ldq_pkg::ST_RUDDER);
				return;
			end
			rudder_hold = 1'b0;

			if (!c.gps_3d_fix) begin
				post(ldq_pkg::ST_NO_FIX);
				return;
			end

			if (!timer_on && min_accel != 0) begin
				if (shake_count <= 1) begin
					if (accel < thr) begin
						halt_timer(ldq_pkg::ST_NO_ACCEL);
						return;
					end
				end else begin
					elapsed = c.now_ms - last_shake_ms;
					if (elapsed > ldq_pkg::SHAKE_WIN_MS)
						shake_events = '0;
					// odd count wants a backward kick, even a forward one
					got = shake_events[0] ? (accel < -thr) : (accel > thr);
					if (got) begin
						if (shake_events != 8'hFF)
							shake_events++;
						last_shake_ms = c.now_ms;
					end
					if (shake_events < shake_count) begin
						halt_timer(ldq_pkg::ST_NO_ACCEL);
						return;
					end
				end
			end

			if (!timer_on) begin
				timer_on = 1'b1;
				timer_start_ms = c.now_ms;
			end
			elapsed = c.now_ms - timer_start_ms;
			if (elapsed > wait_ms + ldq_pkg::WAIT_SLACK_MS) begin
				halt_timer(ldq_pkg::ST_TIMEOUT);
				return;
			end

			if (att_on && (pitch <= ldq_pkg::PITCH_LO || pitch >= ldq_pkg::PITCH_HI ||
					(!c.inverted_flight && roll_abs > ldq_pkg::ROLL_LIM))) begin
				shake_events = '0;
				halt_timer(ldq_pkg::ST_BAD_ATT);
				return;
			end

			if ((c.gnd_speed > min_speed || min_speed == 0) && elapsed >= wait_ms) begin
				halt_timer(ldq_pkg::ST_LAUNCHED);
				return;
			end
			post(ldq_pkg::ST_TIMING);
		endfunction

		function void check_result(ldq_pkg::res_t got);
			ldq_pkg::res_t want;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: %p", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.launch !== want.launch) begin
				$error("launch: expected %0d, got %0d", want.launch, got.launch);
				errors++;
			end
			if (got.rudder_wait !== want.rudder_wait) begin
				$error("rudder_wait: expected %0d, got %0d", want.rudder_wait, got.rudder_wait);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [ldq_pkg::CFG_IDX_W-1:0]  wr_idx;
	logic [ldq_pkg::CFG_DATA_W-1:0] wr_data;

	ldq_chk_if chk_bus();
	ldq_res_if res_bus();

	launch_scoreboard sb = new();
	bit          calm;
	bit          shake_sign;
	logic [31:0] t_ms;
	int          cycles = 0;

	launch_detect_qualifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.chk(chk_bus),
		.res(res_bus)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int idle_draw();
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	task automatic send_check(ldq_pkg::chk_t w);
		int idle;
		idle = idle_draw();
		repeat (idle) begin
			@(negedge clk);
			chk_bus.valid <= 1'b0;
		end
		@(negedge clk);
		chk_bus.valid <= 1'b1;
		chk_bus.data <= w;
		do @(posedge clk); while (chk_bus.ready !== 1'b1);
		sb.note_check(w);
	endtask

	task automatic check_at(logic [31:0] t, int arm, int rud, int neu, int fix,
			int accel, int pitch, int roll, int speed, int inv);
		ldq_pkg::chk_t w;
		w.now_ms = t;
		w.armed = 1'(arm);
		w.rudder_armed = 1'(rud);
		w.rudder_neutral_seen = 1'(neu);
		w.gps_3d_fix = 1'(fix);
		w.fwd_accel = 16'(accel);
		w.pitch_cdeg = 16'(pitch);
		w.roll_cdeg = 16'(roll);
		w.gnd_speed = 16'(speed);
		w.inverted_flight = 1'(inv);
		send_check(w);
	endtask

	task automatic write_reg(logic [ldq_pkg::CFG_IDX_W-1:0] idx,
			logic [ldq_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// drop valid and let every outstanding word drain
	task automatic settle();
		@(negedge clk);
		chk_bus.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_phase(int k);
		logic [14:0] acc;
		logic [6:0]  shk;
		logic [7:0]  dly;
		logic [15:0] spd;
		logic        att;
		if (k == 0) begin
			acc = '1;
			shk = '1;
			dly = '1;
			spd = '1;
			att = 1'b0;
		end else begin
			case ($urandom_range(0, 3))
				0: acc = '0;
				1: acc = '1;
				default: acc = 15'($urandom_range(1, 3000));
			endcase
			case ($urandom_range(0, 4))
				0: shk = '0;
				1: shk = 7'd1;
				2: shk = '1;
				default: shk = 7'($urandom_range(2, 6));
			endcase
			case ($urandom_range(0, 5))
				0: dly = '0;
				1: dly = 8'($urandom_range(127, 255));
				default: dly = 8'($urandom_range(1, 30));
			endcase
			case ($urandom_range(0, 3))
				0: spd = '0;
				1: spd = '1;
				default: spd = 16'($urandom_range(1, 3000));
			endcase
			att = 1'($urandom_range(0, 1));
		end
		// upper data bits beyond each register are noise
		write_reg(ldq_pkg::REG_MIN_ACCEL, {1'($urandom), acc});
		write_reg(ldq_pkg::REG_SHAKE_COUNT, {9'($urandom), shk});
		write_reg(ldq_pkg::REG_DELAY_TENTHS, {8'($urandom), dly});
		write_reg(ldq_pkg::REG_MIN_SPEED, spd);
		write_reg(ldq_pkg::REG_ATT_CHECK, {15'($urandom), att});
		write_reg(ldq_pkg::REG_ATT_CHECK + ldq_pkg::CFG_IDX_W'($urandom_range(1, 3)),
			16'($urandom));
	endtask

	task automatic random_check();
		ldq_pkg::chk_t w;
		int r, mag, thr, spd_min, v;
		r = $urandom_range(0, 99);
		if (r < 80)
			t_ms += $urandom_range(0, 120);
		else if (r < 92)
			t_ms += $urandom_range(121, 200);
		else if (r < 97)
			t_ms += $urandom_range(201, 3000);
		else
			t_ms = $urandom;
		w.now_ms = t_ms;
		w.armed = ($urandom_range(0, 99) < 97);
		w.rudder_armed = ($urandom_range(0, 9) == 0);
		w.rudder_neutral_seen = ($urandom_range(0, 9) < 7);
		w.gps_3d_fix = ($urandom_range(0, 99) < 94);
		w.inverted_flight = ($urandom_range(0, 9) == 0);

		// mostly alternating kicks past the threshold, as a hand shake would give
		thr = int'(sb.min_accel);
		r = $urandom_range(0, 99);
		if (r < 70) begin
			mag = thr + $urandom_range(1, 3000);
			if (mag > 32767)
				mag = 32767;
			shake_sign = !shake_sign;
			v = shake_sign ? -mag : mag;
		end else if (r < 85)
			v = int'($urandom_range(0, 2 * thr)) - thr;
		else
			v = $urandom;
		w.fwd_accel = 16'(v);

		r = $urandom_range(0, 99);
		if (r < 85)
			v = int'($urandom_range(0, 7498)) - 2999;
		else if (r < 92)
			case ($urandom_range(0, 3))
				0: v = int'(ldq_pkg::PITCH_LO);
				1: v = ldq_pkg::PITCH_LO + 1;
				2: v = int'(ldq_pkg::PITCH_HI);
				default: v = ldq_pkg::PITCH_HI - 1;
			endcase
		else
			v = $urandom;
		w.pitch_cdeg = 16'(v);

		r = $urandom_range(0, 99);
		if (r < 85)
			v = int'($urandom_range(0, 6000)) - ldq_pkg::ROLL_LIM;
		else if (r < 92)
			v = $urandom_range(0, 1) ? ldq_pkg::ROLL_LIM + 1 : -ldq_pkg::ROLL_LIM - 1;
		else
			v = $urandom;
		w.roll_cdeg = 16'(v);

		spd_min = int'(sb.min_speed);
		r = $urandom_range(0, 99);
		if (r < 60 && spd_min < 65535)
			v = $urandom_range(spd_min + 1, 65535);
		else if (r < 90)
			v = $urandom_range(0, spd_min);
		else
			v = $urandom;
		w.gnd_speed = 16'(v);
		send_check(w);
	endtask

	initial begin : result_sink
		int stall;
		res_bus.ready = 1'b0;
		forever begin
			stall = idle_draw();
			repeat (stall) begin
				@(negedge clk);
				res_bus.ready <= 1'b0;
			end
			@(negedge clk);
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (res_bus.valid !== 1'b1);
			sb.check_result(res_bus.data);
		end
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		chk_bus.valid = 1'b0;
		chk_bus.data = '0;
		calm = 1'b0;
		shake_sign = 1'b0;
		t_ms = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default settings: no accel or speed gate, no wait, attitude check on
		check_at(0, 0, 0, 1, 1, 0, 0, 0, 0, 0);
		check_at(0, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		check_at(500, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		check_at(700, 1, 1, 0, 1, 0, 0, 0, 0, 0);
		check_at(901, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		check_at(1000, 1, 0, 1, 0, 0, 0, 0, 0, 0);
		check_at(1100, 1, 0, 1, 1, 0, -3000, 0, 0, 0);
		check_at(1150, 1, 0, 1, 1, 0, 4500, 0, 0, 0);
		check_at(1200, 1, 0, 1, 1, 0, -2999, 32767, 0, 1);
		check_at(1250, 1, 0, 1, 1, 0, 0, -3001, 0, 0);
		check_at(1300, 1, 0, 1, 1, -32768, 4499, 3000, 65535, 0);
		check_at(32'hFFFF_FFF0, 1, 0, 1, 1, 32767, 0, -32768, 0, 1);
		check_at(32'hFFFF_FFF0, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		check_at(32'h0000_0010, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		settle();
		write_reg(ldq_pkg::REG_MIN_ACCEL, 16'd1000);
		write_reg(ldq_pkg::REG_DELAY_TENTHS, 16'd5);
		write_reg(ldq_pkg::REG_MIN_SPEED, 16'd1000);
		// single threshold, 500 ms wait, then timeout one past the slack
		check_at(100, 1, 0, 1, 1, 999, 0, 0, 1001, 0);
		check_at(150, 1, 0, 1, 1, 1000, 0, 0, 1001, 0);
		check_at(350, 1, 0, 1, 1, 0, 0, 0, 1001, 0);
		check_at(550, 1, 0, 1, 1, 0, 0, 0, 1001, 0);
		check_at(700, 1, 0, 1, 1, 0, 0, 0, 1000, 0);
		check_at(751, 1, 0, 1, 1, 0, 0, 0, 1000, 0);
		check_at(800, 1, 0, 1, 1, 32767, 0, 0, 0, 0);
		check_at(1000, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		check_at(1200, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		check_at(1300, 1, 0, 1, 1, 0, 0, 0, 1001, 0);

		t_ms = 32'd1300;
		for (int k = 0; k < PHASES; k++) begin
			settle();
			program_phase(k);
			for (int i = 0; i < CHECKS_PER_PHASE; i++) begin
				if (i % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				random_check();
			end
		end

		settle();
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
